/* rtl/core/pwi_pkg.sv */
// shared types, register indexes and helpers for the windowed-integral pid block
package pwi_pkg;

  // default depth of the integral ring
  localparam int WINDOW_MAX_DEF = 256;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_P        = 3'd0;
  localparam logic [2:0] REG_GAIN_I        = 3'd1;
  localparam logic [2:0] REG_GAIN_D        = 3'd2;
  localparam logic [2:0] REG_DRIVE_FLOOR   = 3'd3;
  localparam logic [2:0] REG_DRIVE_CEILING = 3'd4;
  localparam logic [2:0] REG_WINDOW_LENGTH = 3'd5;
  localparam logic [2:0] REG_STEP_TIME     = 3'd6;
  localparam logic [2:0] REG_STEP_RATE     = 3'd7;

  // input operation codes
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // shared multiplier operand widths
  localparam int MUL_AW = 35;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDT,
    ST_DIFF,
    ST_PROP,
    ST_DERIV,
    ST_ILO,
    ST_IHI,
    ST_SUM,
    ST_OUT
  } state_t;

  // saturate a 49-bit sum to 48 bits signed
  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] res;
    if (v[48] != v[47]) begin
      res = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      res = v[47:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/pid_windowed_integral_top.sv */
// top level of the pid controller with sliding-window integral
//
// Input channel: in_valid/in_ready with in_operation, in_setpoint, in_measured.
// A process word yields one out_drive word on out_valid/out_ready; a clear word
// yields nothing and zeroes the history, the running total and the last error.
// Configuration: cfg_valid/cfg_ready write cfg_data into register cfg_index;
// cfg_ready is always high, writes belong in idle periods.
// Between acceptance and out_valid of a process word, a single
// 35x17 multiplier is stepped through six products (error*dt, derivative,
// P, D and the integral in two halves), and the ring of past errors is read
// and written once through its ram, which has one write and one read port. A new word is accepted in the
// cycle after the result is loaded, so one word is finished before the next is taken.
// After reset, and after every clear word, a clearing pass zeroes every entry
// of the ring, one entry a cycle; in_ready stays low meanwhile.
// out_drive sits in an output register; while the receiver stalls, the next
// word is still accepted and worked on, and it waits in its final step until
// the output register is free.
module pid_windowed_integral_top #(
  parameter int WINDOW_MAX = pwi_pkg::WINDOW_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic signed [15:0] in_setpoint,
  input  logic signed [15:0] in_measured,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_drive,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);

  // configuration registers
  logic signed [15:0] gain_p_r, gain_i_r, gain_d_r, floor_r, ceil_r;
  logic [8:0]         window_r;
  logic [15:0]        step_time_r, step_rate_r;

  // controller state
  pwi_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]      clr_cnt_r;
  logic [CW-1:0]      fill_r;
  logic [AW-1:0]      wslot_r;
  logic signed [47:0] total_r;
  logic signed [16:0] last_err_r;

  // per-word working registers
  logic signed [16:0] err_r;
  logic [CW-1:0]      win_r;
  logic [AW-1:0]      slot_r;
  logic               full_r;
  logic signed [31:0] edt_r;
  logic signed [34:0] deriv_r;
  logic signed [65:0] acc_r;

  // output register
  logic               out_valid_r;
  logic signed [15:0] out_drive_r;

  // multiplier and ram hookup
  logic signed [pwi_pkg::MUL_AW-1:0] mul_a;
  logic signed [pwi_pkg::MUL_BW-1:0] mul_b;
  logic signed [pwi_pkg::MUL_PW-1:0] prod;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata, ram_q;

  logic               in_fire, out_load;
  logic [CW-1:0]      win_cur;
  logic [AW-1:0]      slot_cur;
  logic signed [16:0] err_in;
  logic signed [17:0] err_diff;
  logic signed [65:0] prod_ext, addend;
  logic signed [31:0] edt_sat;
  logic signed [47:0] total_sub, total_add;
  logic signed [45:0] drv_full;
  logic signed [15:0] drv_clamp;
  logic [AW-1:0]      slot_inc;

  assign in_ready  = (state_r == pwi_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // effective window, slot wrap and error for the incoming word
  always_comb begin
    if (32'(window_r) > WINDOW_MAX) begin
      win_cur = CW'(WINDOW_MAX);
    end else begin
      win_cur = CW'(window_r);
    end
    if (32'(wslot_r) >= 32'(win_cur)) begin
      slot_cur = '0;
    end else begin
      slot_cur = wslot_r;
    end
    err_in = 17'(in_setpoint) - 17'(in_measured);
  end

  assign err_diff = 18'(err_r) - 18'(last_err_r);
  assign slot_inc = (32'(slot_r) + 1 == 32'(win_r)) ? '0 : AW'(32'(slot_r) + 1);

  // saturated error times dt
  always_comb begin
    if (prod[pwi_pkg::MUL_PW-1:31] == '0 || prod[pwi_pkg::MUL_PW-1:31] == '1) begin
      edt_sat = prod[31:0];
    end else begin
      edt_sat = prod[pwi_pkg::MUL_PW-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
  end

  assign total_sub = pwi_pkg::sat48({total_r[47], total_r} - {{17{ram_q[31]}}, ram_q});
  assign total_add = pwi_pkg::sat48({total_r[47], total_r} + {{17{edt_r[31]}}, edt_r});

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      pwi_pkg::ST_EDT: begin
        mul_a = {19'd0, step_time_r};
        mul_b = err_r;
      end
      pwi_pkg::ST_DIFF: begin
        mul_a = {{17{err_diff[17]}}, err_diff};
        mul_b = {1'b0, step_rate_r};
      end
      pwi_pkg::ST_PROP: begin
        mul_a = {{18{err_r[16]}}, err_r};
        mul_b = {gain_p_r[15], gain_p_r};
      end
      pwi_pkg::ST_DERIV: begin
        mul_a = deriv_r;
        mul_b = {gain_d_r[15], gain_d_r};
      end
      pwi_pkg::ST_ILO: begin
        mul_a = {11'd0, total_r[23:0]};
        mul_b = {gain_i_r[15], gain_i_r};
      end
      pwi_pkg::ST_IHI: begin
        mul_a = {{11{total_r[47]}}, total_r[47:24]};
        mul_b = {gain_i_r[15], gain_i_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product alignment into the q20 accumulator
  assign prod_ext = {{(66 - pwi_pkg::MUL_PW){prod[pwi_pkg::MUL_PW-1]}}, prod};
  always_comb begin
    case (state_r)
      pwi_pkg::ST_DERIV, pwi_pkg::ST_ILO: addend = prod_ext <<< 12;
      pwi_pkg::ST_SUM:                    addend = prod_ext <<< 24;
      default:                            addend = prod_ext;
    endcase
  end

  // final shift and clamp
  assign drv_full = acc_r[65:20];
  always_comb begin
    logic signed [45:0] tmp;
    tmp = drv_full;
    if (tmp > 46'(ceil_r)) begin
      tmp = 46'(ceil_r);
    end
    if (tmp < 46'(floor_r)) begin
      tmp = 46'(floor_r);
    end
    drv_clamp = tmp[15:0];
  end

  assign out_load = (state_r == pwi_pkg::ST_OUT) && (!out_valid_r || out_ready);

  // ring ports
  always_comb begin
    ram_re    = (state_r == pwi_pkg::ST_EDT);
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = edt_r;
    if (state_r == pwi_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == pwi_pkg::ST_DERIV && win_r != '0) begin
      ram_we = 1'b1;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pwi_pkg::ST_CLEAR: begin
        if (clr_cnt_r == AW'(WINDOW_MAX - 1)) begin
          state_nxt = pwi_pkg::ST_IDLE;
        end
      end
      pwi_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_operation == pwi_pkg::OP_CLEAR) ? pwi_pkg::ST_CLEAR
                                                          : pwi_pkg::ST_EDT;
        end
      end
      pwi_pkg::ST_EDT:   state_nxt = pwi_pkg::ST_DIFF;
      pwi_pkg::ST_DIFF:  state_nxt = pwi_pkg::ST_PROP;
      pwi_pkg::ST_PROP:  state_nxt = pwi_pkg::ST_DERIV;
      pwi_pkg::ST_DERIV: state_nxt = pwi_pkg::ST_ILO;
      pwi_pkg::ST_ILO:   state_nxt = pwi_pkg::ST_IHI;
      pwi_pkg::ST_IHI:   state_nxt = pwi_pkg::ST_SUM;
      pwi_pkg::ST_SUM:   state_nxt = pwi_pkg::ST_OUT;
      pwi_pkg::ST_OUT: begin
        if (out_load) begin
          state_nxt = pwi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pwi_pkg::ST_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwi_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= 16'sd256;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      floor_r     <= 16'sh8000;
      ceil_r      <= 16'sh7fff;
      window_r    <= '0;
      step_time_r <= 16'd4096;
      step_rate_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pwi_pkg::REG_GAIN_P:        gain_p_r    <= cfg_data;
        pwi_pkg::REG_GAIN_I:        gain_i_r    <= cfg_data;
        pwi_pkg::REG_GAIN_D:        gain_d_r    <= cfg_data;
        pwi_pkg::REG_DRIVE_FLOOR:   floor_r     <= cfg_data;
        pwi_pkg::REG_DRIVE_CEILING: ceil_r      <= cfg_data;
        pwi_pkg::REG_WINDOW_LENGTH: window_r    <= cfg_data[8:0];
        pwi_pkg::REG_STEP_TIME:     step_time_r <= cfg_data;
        pwi_pkg::REG_STEP_RATE:     step_rate_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // controller state and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      fill_r     <= '0;
      wslot_r    <= '0;
      total_r    <= '0;
      last_err_r <= '0;
    end else begin
      case (state_r)
        pwi_pkg::ST_CLEAR: begin
          clr_cnt_r  <= clr_cnt_r + 1'b1;
          fill_r     <= '0;
          wslot_r    <= '0;
          total_r    <= '0;
          last_err_r <= '0;
        end
        pwi_pkg::ST_IDLE: begin
          clr_cnt_r <= '0;
        end
        pwi_pkg::ST_PROP: begin
          last_err_r <= err_r;
          if (win_r != '0 && full_r) begin
            total_r <= total_sub;
          end
        end
        pwi_pkg::ST_DERIV: begin
          total_r <= total_add;
          if (win_r != '0) begin
            wslot_r <= slot_inc;
            fill_r  <= full_r ? win_r : fill_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // per-word datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r  <= err_in;
      win_r  <= win_cur;
      slot_r <= slot_cur;
      full_r <= (32'(fill_r) >= 32'(win_cur));
    end
    case (state_r)
      pwi_pkg::ST_DIFF: edt_r <= edt_sat;
      pwi_pkg::ST_PROP: deriv_r <= (last_err_r != '0) ? prod[34:0] : '0;
      pwi_pkg::ST_DERIV: acc_r <= addend;
      pwi_pkg::ST_ILO, pwi_pkg::ST_IHI, pwi_pkg::ST_SUM: acc_r <= acc_r + addend;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive_r <= drv_clamp;
    end
  end

  pwi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  pwi_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_q)
  );

endmodule

/* rtl/core/pwi_ram.sv */
// generic single write port ram with registered read
module pwi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/pwi_mul.sv */
// shared signed multiplier with registered product
module pwi_mul (
  input  logic                             clk,
  input  logic signed [pwi_pkg::MUL_AW-1:0] a,
  input  logic signed [pwi_pkg::MUL_BW-1:0] b,
  output logic signed [pwi_pkg::MUL_PW-1:0] p
);

  // one product per cycle
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* verif/tb.sv */
// testbench for the windowed-integral pid controller: directed table, random words, drive checks
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW        = pwi_pkg::WINDOW_MAX_DEF;
  localparam int SETTLE_CYCLES = 300;   // clearing pass plus one word
  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 288;
  localparam int RANDOM_WORDS  = PHASES * PHASE_WORDS;
  localparam int SCRIPT_ROWS   = 39;

  localparam longint ERR_HI = 64'sd2147483647;
  localparam longint ERR_LO = -64'sd2147483648;
  localparam longint TOT_HI = (64'sd1 <<< 47) - 64'sd1;
  localparam longint TOT_LO = -(64'sd1 <<< 47);

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // block ports
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic               in_operation = pwi_pkg::OP_PROCESS;
  logic signed [15:0] in_setpoint  = '0;
  logic signed [15:0] in_measured  = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic signed [15:0] out_drive;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index    = pwi_pkg::REG_GAIN_P;
  logic [15:0]        cfg_data     = '0;

  pid_windowed_integral_top #(
    .WINDOW_MAX(WINDOW)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_setpoint (in_setpoint),
    .in_measured (in_measured),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_drive   (out_drive),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // controller registers as the block should hold them
  logic signed [15:0] kp      = 16'sd256;
  logic signed [15:0] ki      = 16'sd0;
  logic signed [15:0] kd      = 16'sd0;
  logic signed [15:0] lo_lim  = 16'sh8000;
  logic signed [15:0] hi_lim  = 16'sh7fff;
  logic [8:0]         win_len = 9'd0;
  logic [15:0]        dt      = 16'h1000;
  logic [15:0]        rate    = 16'h0001;

  // controller state: error ring, fill level, write slot, integral, last error
  logic signed [31:0] hist [WINDOW];
  int unsigned        fill_cnt;
  int unsigned        slot;
  longint             total;
  longint             prev_err;

  // drive values still owed by the block, oldest first
  logic signed [15:0] drive_due [$];

  int send_idle  = 26;
  int stall_pct  = 54;
  int mismatches = 0;
  int words_sent = 0;
  int clears_sent = 0;
  int drives_seen = 0;
  int reg_writes = 0;

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic void clear_history();
    foreach (hist[i]) hist[i] = '0;
    fill_cnt = 0;
    slot     = 0;
    total    = 0;
    prev_err = 0;
  endfunction

  // one controller step; returns 1 when a drive word is produced
  function automatic logic pid_update(input logic op, input logic signed [15:0] sp,
                                      input logic signed [15:0] ms,
                                      output logic signed [15:0] drv);
    longint      err;
    longint      err_dt;
    longint      deriv;
    longint      acc;
    longint      d;
    int unsigned w;
    drv = '0;
    if (op == pwi_pkg::OP_CLEAR) begin
      clear_history();
      return 1'b0;
    end
    err    = longint'(sp) - longint'(ms);
    err_dt = clip(err * longint'(dt), ERR_LO, ERR_HI);

    // windowed ring or unbounded sum
    w = (win_len > WINDOW) ? WINDOW : int'(win_len);
    if (w > 0) begin
      if (slot >= w) slot = 0;
      if (fill_cnt >= w) begin
        total    = total - hist[slot];
        fill_cnt = w;
      end else begin
        fill_cnt++;
      end
      total      = clip(total, TOT_LO, TOT_HI);
      hist[slot] = err_dt[31:0];
      total      = clip(total + err_dt, TOT_LO, TOT_HI);
      slot       = (slot + 1) % w;
    end else begin
      total = clip(total + err_dt, TOT_LO, TOT_HI);
    end

    // derivative skipped right after a zero error
    deriv = 0;
    if (prev_err != 0) deriv = (err - prev_err) * longint'(rate);
    prev_err = err;

    // p and d in q.8, i brought down from q.20, then floor to integer
    acc = longint'(kp) * err + longint'(kd) * deriv + ((longint'(ki) * total) >>> 12);
    d   = acc >>> 8;
    if (d > hi_lim) d = hi_lim;
    if (d < lo_lim) d = lo_lim;
    drv = d[15:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] drive check: %s", $time, what);
  endtask

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each drive word against the oldest prediction
  always @(posedge clk) begin : check_drive
    logic signed [15:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (drive_due.size() == 0) begin
        report_mismatch($sformatf("drive %0d arrived with nothing pending", out_drive));
      end else begin
        want = drive_due.pop_front();
        drives_seen++;
        if (out_drive !== want)
          report_mismatch($sformatf("drive %0d, predicted %0d", out_drive, want));
      end
    end
  end

  // directed table rows
  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               op;
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;
    logic [2:0]         reg_idx;
    logic [15:0]        reg_data;
    logic               typed;
    logic signed [15:0] want;
  } row_t;

  function automatic row_t word_row(input logic op, input logic signed [15:0] sp,
                                    input logic signed [15:0] ms);
    row_t r;
    r          = '0;
    r.kind     = ROW_WORD;
    r.op       = op;
    r.setpoint = sp;
    r.measured = ms;
    return r;
  endfunction

  function automatic row_t checked_row(input logic signed [15:0] sp,
                                       input logic signed [15:0] ms,
                                       input logic signed [15:0] want);
    row_t r;
    r       = word_row(pwi_pkg::OP_PROCESS, sp, ms);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [2:0] idx, input logic [15:0] data);
    row_t r;
    r          = '0;
    r.kind     = ROW_REG;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(2048) - 1024);
    endcase
  endfunction

  // one register write; valid stays up for back-to-back writes
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pwi_pkg::REG_GAIN_P:        kp      = data;
      pwi_pkg::REG_GAIN_I:        ki      = data;
      pwi_pkg::REG_GAIN_D:        kd      = data;
      pwi_pkg::REG_DRIVE_FLOOR:   lo_lim  = data;
      pwi_pkg::REG_DRIVE_CEILING: hi_lim  = data;
      pwi_pkg::REG_WINDOW_LENGTH: win_len = data[8:0];
      pwi_pkg::REG_STEP_TIME:     dt      = data;
      pwi_pkg::REG_STEP_RATE:     rate    = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // one input word, after a random sender gap
  task automatic send_word(input logic op, input logic signed [15:0] sp,
                           input logic signed [15:0] ms, input logic typed,
                           input logic signed [15:0] want);
    logic signed [15:0] drv;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_setpoint  <= sp;
    in_measured  <= ms;
    do @(posedge clk); while (!in_ready);
    if (pid_update(op, sp, ms, drv)) drive_due.push_back(typed ? want : drv);
    words_sent++;
    if (op == pwi_pkg::OP_CLEAR) clears_sent++;
  endtask

  // hold the sender until every owed drive word is in
  task automatic wait_results();
    in_valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
  endtask

  // idle long enough for a clearing pass before touching registers
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    row_t               script [SCRIPT_ROWS];
    logic [15:0]        vals [8];
    logic               op;
    logic signed [15:0] sp;
    logic signed [15:0] ms;
    logic [8:0]         win;
    bit                 dirty;
    int                 k;

    clear_history();
    dirty = 1'b0;
    k     = 0;

    script = '{
      // reset settings: drive is the plain error, clamped
      checked_row(16'sd100, 16'sd30, 16'sd70),
      checked_row(16'sh7fff, 16'sh8000, 16'sh7fff),
      checked_row(16'sh8000, 16'sh7fff, 16'sh8000),
      checked_row(16'sd0, 16'sd0, 16'sd0),
      word_row(pwi_pkg::OP_CLEAR, 16'shffff, 16'sh5a5a),
      // floor above ceiling forces the floor
      reg_row(pwi_pkg::REG_DRIVE_FLOOR, 16'h7fff),
      reg_row(pwi_pkg::REG_DRIVE_CEILING, 16'h8000),
      checked_row(16'sd5, 16'sd0, 16'sh7fff),
      reg_row(pwi_pkg::REG_DRIVE_FLOOR, 16'h8000),
      reg_row(pwi_pkg::REG_DRIVE_CEILING, 16'h7fff),
      // zero dt and zero rate
      reg_row(pwi_pkg::REG_GAIN_I, 16'h0100),
      reg_row(pwi_pkg::REG_GAIN_D, 16'h0040),
      reg_row(pwi_pkg::REG_WINDOW_LENGTH, 16'd3),
      reg_row(pwi_pkg::REG_STEP_TIME, 16'h0000),
      reg_row(pwi_pkg::REG_STEP_RATE, 16'h0000),
      word_row(pwi_pkg::OP_PROCESS, 16'sd1000, 16'sd0),
      word_row(pwi_pkg::OP_PROCESS, 16'sd0, 16'sd1000),
      // scaled error saturates, derivative at full rate
      reg_row(pwi_pkg::REG_STEP_TIME, 16'hffff),
      reg_row(pwi_pkg::REG_STEP_RATE, 16'hffff),
      word_row(pwi_pkg::OP_PROCESS, 16'sh7fff, 16'sh8000),
      word_row(pwi_pkg::OP_PROCESS, 16'sh8000, 16'sh7fff),
      word_row(pwi_pkg::OP_PROCESS, 16'sd0, 16'sd0),
      word_row(pwi_pkg::OP_PROCESS, 16'sd1, 16'sd0),
      // window beyond the ring depth
      reg_row(pwi_pkg::REG_WINDOW_LENGTH, 16'd300),
      reg_row(pwi_pkg::REG_STEP_TIME, 16'h1000),
      reg_row(pwi_pkg::REG_GAIN_P, 16'h8000),
      word_row(pwi_pkg::OP_PROCESS, 16'sd200, 16'sd100),
      word_row(pwi_pkg::OP_PROCESS, -16'sd50, 16'sd50),
      word_row(pwi_pkg::OP_PROCESS, 16'sd7, 16'sd7),
      // window shrunk below slot and fill level
      reg_row(pwi_pkg::REG_WINDOW_LENGTH, 16'd2),
      reg_row(pwi_pkg::REG_GAIN_P, 16'h7fff),
      word_row(pwi_pkg::OP_PROCESS, 16'sd300, 16'sd0),
      word_row(pwi_pkg::OP_PROCESS, -16'sd300, 16'sd0),
      word_row(pwi_pkg::OP_PROCESS, 16'sd10, 16'sd20),
      // unbounded sum, then clear
      reg_row(pwi_pkg::REG_WINDOW_LENGTH, 16'd0),
      word_row(pwi_pkg::OP_PROCESS, 16'sd1000, -16'sd1000),
      word_row(pwi_pkg::OP_PROCESS, 16'sd1, 16'sd2),
      word_row(pwi_pkg::OP_CLEAR, 16'sd0, 16'sd0),
      word_row(pwi_pkg::OP_PROCESS, 16'sd1, 16'sd1)
    };

    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        if (dirty) begin
          settle();
          dirty = 1'b0;
        end
        write_reg(script[i].reg_idx, script[i].reg_data);
      end else begin
        send_word(script[i].op, script[i].setpoint, script[i].measured,
                  script[i].typed, script[i].want);
        dirty = 1'b1;
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) begin
        vals[pwi_pkg::REG_GAIN_P]        = 16'h7fff;
        vals[pwi_pkg::REG_GAIN_I]        = 16'h7fff;
        vals[pwi_pkg::REG_GAIN_D]        = 16'h7fff;
        vals[pwi_pkg::REG_DRIVE_FLOOR]   = 16'h8000;
        vals[pwi_pkg::REG_DRIVE_CEILING] = 16'h7fff;
        vals[pwi_pkg::REG_WINDOW_LENGTH] = 16'd256;
        vals[pwi_pkg::REG_STEP_TIME]     = 16'hffff;
        vals[pwi_pkg::REG_STEP_RATE]     = 16'hffff;
      end else if (p == 1) begin
        vals[pwi_pkg::REG_GAIN_P]        = 16'h8000;
        vals[pwi_pkg::REG_GAIN_I]        = 16'h8000;
        vals[pwi_pkg::REG_GAIN_D]        = 16'h8000;
        vals[pwi_pkg::REG_DRIVE_FLOOR]   = 16'h8000;
        vals[pwi_pkg::REG_DRIVE_CEILING] = 16'h7fff;
        vals[pwi_pkg::REG_WINDOW_LENGTH] = {7'h7f, 9'd0};
        vals[pwi_pkg::REG_STEP_TIME]     = 16'h0001;
        vals[pwi_pkg::REG_STEP_RATE]     = 16'h0001;
      end else begin
        vals[pwi_pkg::REG_GAIN_P] = pick_gain();
        vals[pwi_pkg::REG_GAIN_I] = pick_gain();
        vals[pwi_pkg::REG_GAIN_D] = pick_gain();
        vals[pwi_pkg::REG_DRIVE_FLOOR]   = 16'h8000;
        vals[pwi_pkg::REG_DRIVE_CEILING] = 16'h7fff;
        case ($urandom_range(3))
          0: begin
            vals[pwi_pkg::REG_DRIVE_FLOOR]   = 16'($urandom);
            vals[pwi_pkg::REG_DRIVE_CEILING] = 16'($urandom);
          end
          1: begin
            vals[pwi_pkg::REG_DRIVE_FLOOR]   = -16'($urandom_range(4000));
            vals[pwi_pkg::REG_DRIVE_CEILING] = 16'($urandom_range(4000));
          end
          default: ;
        endcase
        case ($urandom_range(5))
          0:       win = 9'd0;
          1:       win = 9'd1;
          2:       win = 9'd256;
          3:       win = 9'($urandom_range(511, 257));
          default: win = 9'($urandom_range(24, 2));
        endcase
        vals[pwi_pkg::REG_WINDOW_LENGTH] = {7'($urandom), win};
        case ($urandom_range(5))
          0:       vals[pwi_pkg::REG_STEP_TIME] = 16'h0001;
          1:       vals[pwi_pkg::REG_STEP_TIME] = 16'hffff;
          2:       vals[pwi_pkg::REG_STEP_TIME] = 16'h0000;
          default: vals[pwi_pkg::REG_STEP_TIME] = 16'($urandom_range(8192, 1));
        endcase
        case ($urandom_range(5))
          0:       vals[pwi_pkg::REG_STEP_RATE] = 16'h0000;
          1:       vals[pwi_pkg::REG_STEP_RATE] = 16'h0001;
          2:       vals[pwi_pkg::REG_STEP_RATE] = 16'hffff;
          default: vals[pwi_pkg::REG_STEP_RATE] = 16'($urandom_range(64, 1));
        endcase
      end
      for (int r = 0; r < 8; r++) write_reg(3'(r), vals[r]);

      repeat (PHASE_WORDS) begin
        // receiver busy first, then sender busy, then both free-running
        if (k < RANDOM_WORDS / 3) begin
          send_idle = 26;
          stall_pct = 54;
        end else if (k < 2 * RANDOM_WORDS / 3) begin
          send_idle = 54;
          stall_pct = 26;
        end else begin
          send_idle = 0;
          stall_pct = 0;
        end
        if ($urandom_range(99) == 0) wait_results();

        op = ($urandom_range(99) < 3) ? pwi_pkg::OP_CLEAR : pwi_pkg::OP_PROCESS;
        sp = 16'($urandom);
        if ($urandom_range(1)) ms = 16'($urandom);
        else ms = sp + 16'($urandom_range(128)) - 16'sd64;
        send_word(op, sp, ms, 1'b0, '0);
        k++;
      end
    end

    // drain and let any clearing pass finish
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d clears) over %0d register writes in %0d settings",
             words_sent, clears_sent, reg_writes, PHASES + 1);
    $display("checked %0d drive words, %0d disagreements", drives_seen, mismatches);
    if (mismatches == 0) begin
      $display("pid_windowed_integral_top: match");
    end else begin
      $display("pid_windowed_integral_top: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(5_000_000);
    $display("pid_windowed_integral_top: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pwi_pkg.sv
rtl/core/pwi_ram.sv
rtl/core/pwi_mul.sv
rtl/core/pid_windowed_integral_top.sv
verif/tb.sv
